/* rtl/core/kmp_pkg.sv */
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared constants and types of the KMP substring matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package kmp_pkg;

  localparam int KMP_MAX_NEEDLE  = 16;
  localparam int KMP_OFFSET_BITS = 16;

  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_LEN_BITS   = 5;
  localparam int HAY_BITS       = 8;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_NEEDLE_LOW    = 2'd0,
    CFG_NEEDLE_HIGH   = 2'd1,
    CFG_NEEDLE_LENGTH = 2'd2
  } cfg_reg_t;

  // Link builder status seen by the scanner and the top level
  typedef struct packed {
    logic restart;  // rebuild starts this cycle: drop the partial match
    logic busy;     // link table is being rebuilt
  } build_status_t;

endpackage

`default_nettype wire

/* rtl/core/kmp_ram.sv */
// ----------------------------------------------------------------------------
// kmp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/kmp_link_builder.sv */
// ----------------------------------------------------------------------------
// kmp_link_builder
// Rebuilds the KMP failure-link table in the link RAM from the needle.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_link_builder import kmp_pkg::*; #(
  parameter int MAX_NEEDLE = KMP_MAX_NEEDLE,
  localparam int IDX_BITS = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1,
  localparam int LEN_BITS = $clog2(MAX_NEEDLE + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [7:0]              needle [MAX_NEEDLE],
  input  logic [CFG_LEN_BITS-1:0] needle_length,
  output build_status_t           status,
  output logic [LEN_BITS-1:0]     active_len,
  output logic [IDX_BITS-1:0]     last_link,
  output logic                    ram_we,
  output logic [IDX_BITS-1:0]     ram_waddr,
  output logic [IDX_BITS-1:0]     ram_wdata,
  output logic [IDX_BITS-1:0]     ram_raddr,
  input  logic [IDX_BITS-1:0]     ram_rdata
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_CMP,
    B_WAIT
  } build_state_t;

  build_state_t        state;
  logic [LEN_BITS-1:0] i;
  logic [IDX_BITS-1:0] k;
  logic [LEN_BITS-1:0] len_eff;
  logic [7:0]          byte_i;
  logic [7:0]          byte_k;
  logic                bytes_eq;
  logic [IDX_BITS-1:0] k_next;

  // Clamp the programmed length into 1..MAX_NEEDLE
  always_comb begin
    if (needle_length == '0) begin
      len_eff = LEN_BITS'(1);
    end else if (32'(needle_length) > MAX_NEEDLE) begin
      len_eff = LEN_BITS'(MAX_NEEDLE);
    end else begin
      len_eff = LEN_BITS'(needle_length);
    end
  end

  assign byte_i   = needle[IDX_BITS'(i)];
  assign byte_k   = needle[k];
  assign bytes_eq = (byte_i == byte_k);
  assign k_next   = k + IDX_BITS'(bytes_eq);

  assign status.busy    = (state != B_IDLE);
  assign status.restart = start && (state == B_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = k - IDX_BITS'(1);
    case (state)
      B_IDLE: begin
        if (start) begin
          ram_we = 1'b1;
        end
      end
      B_CMP: begin
        if (i < active_len && !(k != '0 && !bytes_eq)) begin
          ram_we    = 1'b1;
          ram_waddr = IDX_BITS'(i);
          ram_wdata = k_next;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      i          <= '0;
      k          <= '0;
      active_len <= LEN_BITS'(1);
      last_link  <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (start) begin
            active_len <= len_eff;
            last_link  <= '0;
            i          <= LEN_BITS'(1);
            k          <= '0;
            state      <= B_CMP;
          end
        end
        B_CMP: begin
          if (i >= active_len) begin
            state <= B_IDLE;
          end else if (k != '0 && !bytes_eq) begin
            state <= B_WAIT;
          end else begin
            k <= k_next;
            if (i == active_len - LEN_BITS'(1)) begin
              last_link <= k_next;
            end
            i <= i + LEN_BITS'(1);
          end
        end
        B_WAIT: begin
          k     <= ram_rdata;
          state <= B_CMP;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // The border being extended is always shorter than the prefix scanned
  assert property (@(posedge clk) disable iff (rst)
    (state == B_CMP && i < active_len) |-> (LEN_BITS'(k) < i))
    else $error("link builder: border not shorter than prefix");

  // A fallback read is only issued for a nonzero border
  assert property (@(posedge clk) disable iff (rst)
    (state == B_WAIT) |-> (k != '0))
    else $error("link builder: fallback from empty border");

endmodule

`default_nettype wire

/* rtl/core/kmp_scanner.sv */
// ----------------------------------------------------------------------------
// kmp_scanner
// Per-byte KMP match walk, offset tracking, summary and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_scanner import kmp_pkg::*; #(
  parameter int MAX_NEEDLE  = KMP_MAX_NEEDLE,
  parameter int OFFSET_BITS = KMP_OFFSET_BITS,
  localparam int IDX_BITS = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1,
  localparam int LEN_BITS = $clog2(MAX_NEEDLE + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  build_status_t          status,
  input  logic                   take_ok,
  input  logic [7:0]             needle [MAX_NEEDLE],
  input  logic [LEN_BITS-1:0]    active_len,
  input  logic [IDX_BITS-1:0]    last_link,
  output logic [IDX_BITS-1:0]    ram_raddr,
  input  logic [IDX_BITS-1:0]    ram_rdata,
  output logic                   idle,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [HAY_BITS-1:0]    hay_byte,
  input  logic                   final_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   match_here,
  output logic [OFFSET_BITS-1:0] match_start,
  output logic                   any_found,
  output logic [OFFSET_BITS-1:0] first_start,
  output logic [OFFSET_BITS-1:0] last_start,
  output logic                   end_of_haystack,
  output logic                   offset_overflow
);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_WAIT
  } scan_state_t;

  scan_state_t          state;
  logic [LEN_BITS-1:0]  m;
  logic [HAY_BITS-1:0]  cur_byte;
  logic                 cur_last;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic                 seen_match;
  logic [OFFSET_BITS-1:0] first_offset;
  logic [OFFSET_BITS-1:0] latest_offset;
  logic                 saturated;

  logic                 byte_eq;
  logic                 fall_back;
  logic                 slot_free;
  logic                 emit;
  logic [LEN_BITS-1:0]  m_next;
  logic                 hit;
  logic [OFFSET_BITS-1:0] span;
  logic [OFFSET_BITS-1:0] start_off;
  logic [OFFSET_BITS-1:0] first_next;

  assign byte_eq   = (needle[IDX_BITS'(m)] == cur_byte);
  assign fall_back = (m != '0) && !byte_eq;
  assign slot_free = !out_valid || out_ready;
  assign emit      = (state == S_MATCH) && !fall_back && slot_free;
  assign m_next    = m + LEN_BITS'(byte_eq);
  assign hit       = (m_next >= active_len);
  assign span      = OFFSET_BITS'(active_len - LEN_BITS'(1));
  assign ram_raddr = IDX_BITS'(m - LEN_BITS'(1));

  always_comb begin
    if (saturated) begin
      start_off = OFF_MAX;
    end else if (byte_offset >= span) begin
      start_off = byte_offset - span;
    end else begin
      start_off = '0;
    end
  end

  assign first_next = seen_match ? first_offset : start_off;

  assign idle     = (state == S_IDLE);
  assign in_ready = idle && take_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m             <= '0;
      out_valid     <= 1'b0;
      byte_offset   <= '0;
      seen_match    <= 1'b0;
      first_offset  <= '0;
      latest_offset <= '0;
      saturated     <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emit) begin
        out_valid <= 1'b0;
      end
      if (status.restart) begin
        m <= '0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cur_byte <= hay_byte;
            cur_last <= final_byte;
            state    <= S_MATCH;
          end
        end
        S_MATCH: begin
          if (fall_back) begin
            state <= S_WAIT;
          end else if (slot_free) begin
            out_valid       <= 1'b1;
            match_here      <= hit;
            match_start     <= hit ? start_off : '0;
            any_found       <= seen_match || hit;
            first_start     <= hit ? first_next : first_offset;
            last_start      <= hit ? start_off : latest_offset;
            end_of_haystack <= cur_last;
            offset_overflow <= saturated;
            if (cur_last) begin
              // Clear per-haystack state for the next one
              m             <= '0;
              byte_offset   <= '0;
              seen_match    <= 1'b0;
              first_offset  <= '0;
              latest_offset <= '0;
              saturated     <= 1'b0;
            end else begin
              m <= hit ? LEN_BITS'(last_link) : m_next;
              if (hit) begin
                seen_match    <= 1'b1;
                first_offset  <= first_next;
                latest_offset <= start_off;
              end
              if (byte_offset == OFF_MAX) begin
                saturated <= 1'b1;
              end else begin
                byte_offset <= byte_offset + OFFSET_BITS'(1);
              end
            end
            state <= S_IDLE;
          end
        end
        S_WAIT: begin
          m     <= LEN_BITS'(ram_rdata);
          state <= S_MATCH;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Between items the partial match is always a proper prefix
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !status.busy) |-> (m < active_len))
    else $error("scanner: partial match not shorter than needle");

  // Once saturated the offset counter sits at its top value
  assert property (@(posedge clk) disable iff (rst)
    saturated |-> (byte_offset == OFF_MAX))
    else $error("scanner: saturated with offset below top");

  // No item is in flight while the link table is rebuilt
  assert property (@(posedge clk) disable iff (rst)
    status.busy |-> (state == S_IDLE))
    else $error("scanner: item in flight during rebuild");

endmodule

`default_nettype wire

/* rtl/core/kmp_substring_matcher.sv */
// ----------------------------------------------------------------------------
// kmp_substring_matcher
// Streaming Knuth-Morris-Pratt substring search against a programmed needle.
// ----------------------------------------------------------------------------
// Haystack bytes arrive one item at a time on the input channel; every input
// item yields exactly one result item, which flags an occurrence of the needle
// ending at that byte (overlaps included) with its start offset, and carries
// a running summary: any occurrence seen, first start and latest start. The
// item marked final_byte closes the haystack: its summary is final and the
// per-haystack state clears afterwards. Offsets count from 0 per haystack and
// saturate at all ones, after which offset_overflow is set and starts found
// from then on report that top value. The needle (up to 16 programmed bytes,
// length 1..MAX_NEEDLE, zero and oversize lengths clamped) lives in three
// config registers; any write to one of them rebuilds the failure-link table
// in a small link RAM, during which cfg_ready and in_ready stay low; the same
// rebuild runs once after reset. Each item compares its byte against the
// needle and, on a mismatch, follows failure links, each step a read of the
// registered link RAM port; it also waits while the output register is full.
// A finished result sits in an output register, so the next item is taken
// while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_substring_matcher import kmp_pkg::*; #(
  parameter int MAX_NEEDLE  = KMP_MAX_NEEDLE,
  parameter int OFFSET_BITS = KMP_OFFSET_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  // haystack input
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [HAY_BITS-1:0]       hay_byte,
  input  logic                      final_byte,
  // results
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      match_here,
  output logic [OFFSET_BITS-1:0]    match_start,
  output logic                      any_found,
  output logic [OFFSET_BITS-1:0]    first_start,
  output logic [OFFSET_BITS-1:0]    last_start,
  output logic                      end_of_haystack,
  output logic                      offset_overflow
);

  localparam int IDX_BITS = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
  localparam int LEN_BITS = $clog2(MAX_NEEDLE + 1);

  // Config registers
  logic [CFG_DATA_BITS-1:0] needle_low;
  logic [CFG_DATA_BITS-1:0] needle_high;
  logic [CFG_LEN_BITS-1:0]  needle_length;
  logic                     rebuild_req;

  logic [7:0]          needle [MAX_NEEDLE];
  build_status_t       status;
  logic [LEN_BITS-1:0] active_len;
  logic [IDX_BITS-1:0] last_link;
  logic                scan_idle;
  logic                cfg_fire;

  logic                ram_we;
  logic [IDX_BITS-1:0] ram_waddr;
  logic [IDX_BITS-1:0] ram_wdata;
  logic [IDX_BITS-1:0] ram_raddr;
  logic [IDX_BITS-1:0] ram_rdata;
  logic [IDX_BITS-1:0] build_raddr;
  logic [IDX_BITS-1:0] scan_raddr;

  // Take config writes only with no item in flight and no rebuild pending
  assign cfg_ready = !status.busy && !rebuild_req && scan_idle;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_low    <= '0;
      needle_high   <= '0;
      needle_length <= CFG_LEN_BITS'(1);
      rebuild_req   <= 1'b1;  // build the table for the reset needle
    end else begin
      rebuild_req <= 1'b0;
      if (cfg_fire) begin
        case (cfg_reg_t'(cfg_index))
          CFG_NEEDLE_LOW: begin
            needle_low  <= cfg_data;
            rebuild_req <= 1'b1;
          end
          CFG_NEEDLE_HIGH: begin
            needle_high <= cfg_data;
            rebuild_req <= 1'b1;
          end
          CFG_NEEDLE_LENGTH: begin
            needle_length <= cfg_data[CFG_LEN_BITS-1:0];
            rebuild_req   <= 1'b1;
          end
          default: begin
            // unknown index: drop the write
          end
        endcase
      end
    end
  end

  // Unpack needle bytes; positions past the two words read as zero
  for (genvar j = 0; j < MAX_NEEDLE; j++) begin : g_needle
    if (j < 8) begin : g_low
      assign needle[j] = needle_low[j*8 +: 8];
    end else if (j < 16) begin : g_high
      assign needle[j] = needle_high[(j-8)*8 +: 8];
    end else begin : g_zero
      assign needle[j] = 8'h00;
    end
  end

  // The builder owns the link RAM read port while it runs
  assign ram_raddr = status.busy ? build_raddr : scan_raddr;

  kmp_ram #(
    .WIDTH (IDX_BITS),
    .DEPTH (MAX_NEEDLE)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kmp_link_builder #(
    .MAX_NEEDLE (MAX_NEEDLE)
  ) u_builder (
    .clk           (clk),
    .rst           (rst),
    .start         (rebuild_req),
    .needle        (needle),
    .needle_length (needle_length),
    .status        (status),
    .active_len    (active_len),
    .last_link     (last_link),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (build_raddr),
    .ram_rdata     (ram_rdata)
  );

  kmp_scanner #(
    .MAX_NEEDLE  (MAX_NEEDLE),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scanner (
    .clk             (clk),
    .rst             (rst),
    .status          (status),
    .take_ok         (!status.busy && !rebuild_req && !cfg_valid),
    .needle          (needle),
    .active_len      (active_len),
    .last_link       (last_link),
    .ram_raddr       (scan_raddr),
    .ram_rdata       (ram_rdata),
    .idle            (scan_idle),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .hay_byte        (hay_byte),
    .final_byte      (final_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .match_here      (match_here),
    .match_start     (match_start),
    .any_found       (any_found),
    .first_start     (first_start),
    .last_start      (last_start),
    .end_of_haystack (end_of_haystack),
    .offset_overflow (offset_overflow)
  );

endmodule

`default_nettype wire
